>>> rtl/core/frame_check_trailer_appender_core_macros.svh
// ----------------------------------------------------------------------------
// Frame check trailer appender assertion macros
// Shared concurrent assertion forms for the trailer appender core.
// ----------------------------------------------------------------------------
`ifndef FRAME_CHECK_TRAILER_APPENDER_CORE_MACROS_SVH
`define FRAME_CHECK_TRAILER_APPENDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCTA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcta assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define FCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcta assertion failed: next-cycle implication");

`endif

>>> rtl/core/fcta_pkg.sv
// ----------------------------------------------------------------------------
// Frame check trailer appender package
// Check constants, mode codes, trailer decode and bytewise CRC functions.
// ----------------------------------------------------------------------------
package fcta_pkg;

	localparam int MODE_W = 5;

	localparam logic [7:0]  CRC8_POLY    = 8'h31;
	localparam logic [7:0]  CRC8_INIT    = 8'hFF;
	localparam logic [15:0] CRC16_POLY   = 16'h1021;
	localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
	localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC32_INIT   = 32'hFFFFFFFF;
	localparam logic [31:0] CRC32_XOROUT = 32'hFFFFFFFF;
	localparam logic [7:0]  SUM8_INIT    = 8'h00;
	localparam logic [7:0]  ASCII_CR     = 8'h0D;

	localparam logic [MODE_W-1:0] MODE_NONE            = 5'd0;
	localparam logic [MODE_W-1:0] MODE_CRC8_RAW        = 5'd1;
	localparam logic [MODE_W-1:0] MODE_CRC8_HEX        = 5'd2;
	localparam logic [MODE_W-1:0] MODE_CRC8_HEX_CR     = 5'd3;
	localparam logic [MODE_W-1:0] MODE_CRC16_RAW_LE    = 5'd4;
	localparam logic [MODE_W-1:0] MODE_CRC16_RAW_BE    = 5'd5;
	localparam logic [MODE_W-1:0] MODE_CRC16_HEX_LE    = 5'd6;
	localparam logic [MODE_W-1:0] MODE_CRC16_HEX_LE_CR = 5'd7;
	localparam logic [MODE_W-1:0] MODE_CRC16_HEX_BE    = 5'd8;
	localparam logic [MODE_W-1:0] MODE_CRC16_HEX_BE_CR = 5'd9;
	localparam logic [MODE_W-1:0] MODE_CRC32_RAW_LE    = 5'd10;
	localparam logic [MODE_W-1:0] MODE_CRC32_RAW_BE    = 5'd11;
	localparam logic [MODE_W-1:0] MODE_CRC32_HEX_LE    = 5'd12;
	localparam logic [MODE_W-1:0] MODE_CRC32_HEX_LE_CR = 5'd13;
	localparam logic [MODE_W-1:0] MODE_CRC32_HEX_BE    = 5'd14;
	localparam logic [MODE_W-1:0] MODE_CRC32_HEX_BE_CR = 5'd15;
	localparam logic [MODE_W-1:0] MODE_SUM8_RAW        = 5'd16;
	localparam logic [MODE_W-1:0] MODE_SUM8_HEX        = 5'd17;
	localparam logic [MODE_W-1:0] MODE_SUM8_HEX_CR     = 5'd18;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_CRC8,
		SRC_CRC16,
		SRC_CRC32,
		SRC_SUM8
	} check_src_t;

	typedef struct packed {
		check_src_t src;
		logic       big_endian;
		logic       hex;
		logic       cr;
	} trailer_cfg_t;

	// Undefined mode codes append nothing, like the none mode.
	function automatic trailer_cfg_t decode_mode(input logic [MODE_W-1:0] mode);
		trailer_cfg_t t;
		t = '{src: SRC_NONE, big_endian: 1'b0, hex: 1'b0, cr: 1'b0};
		unique case (mode)
			MODE_CRC8_RAW:        t = '{SRC_CRC8,  1'b0, 1'b0, 1'b0};
			MODE_CRC8_HEX:        t = '{SRC_CRC8,  1'b0, 1'b1, 1'b0};
			MODE_CRC8_HEX_CR:     t = '{SRC_CRC8,  1'b0, 1'b1, 1'b1};
			MODE_CRC16_RAW_LE:    t = '{SRC_CRC16, 1'b0, 1'b0, 1'b0};
			MODE_CRC16_RAW_BE:    t = '{SRC_CRC16, 1'b1, 1'b0, 1'b0};
			MODE_CRC16_HEX_LE:    t = '{SRC_CRC16, 1'b0, 1'b1, 1'b0};
			MODE_CRC16_HEX_LE_CR: t = '{SRC_CRC16, 1'b0, 1'b1, 1'b1};
			MODE_CRC16_HEX_BE:    t = '{SRC_CRC16, 1'b1, 1'b1, 1'b0};
			MODE_CRC16_HEX_BE_CR: t = '{SRC_CRC16, 1'b1, 1'b1, 1'b1};
			MODE_CRC32_RAW_LE:    t = '{SRC_CRC32, 1'b0, 1'b0, 1'b0};
			MODE_CRC32_RAW_BE:    t = '{SRC_CRC32, 1'b1, 1'b0, 1'b0};
			MODE_CRC32_HEX_LE:    t = '{SRC_CRC32, 1'b0, 1'b1, 1'b0};
			MODE_CRC32_HEX_LE_CR: t = '{SRC_CRC32, 1'b0, 1'b1, 1'b1};
			MODE_CRC32_HEX_BE:    t = '{SRC_CRC32, 1'b1, 1'b1, 1'b0};
			MODE_CRC32_HEX_BE_CR: t = '{SRC_CRC32, 1'b1, 1'b1, 1'b1};
			MODE_SUM8_RAW:        t = '{SRC_SUM8,  1'b0, 1'b0, 1'b0};
			MODE_SUM8_HEX:        t = '{SRC_SUM8,  1'b0, 1'b1, 1'b0};
			MODE_SUM8_HEX_CR:     t = '{SRC_SUM8,  1'b0, 1'b1, 1'b1};
			default:              t = '{SRC_NONE,  1'b0, 1'b0, 1'b0};
		endcase
		return t;
	endfunction

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// Reflected CRC-32: the register shifts toward bit 0.
	function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

endpackage

>>> rtl/core/frame_check_trailer_appender_core.sv
// ----------------------------------------------------------------------------
// Frame check trailer appender core
// Passes frame bytes through; appends a CRC or sum trailer per the check mode.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the frame channel (frame_valid, frame_stall, data_byte,
// frame_end) and leave on the result channel (result_valid, result_stall,
// out_byte, out_last). A beat moves when valid is high and stall is low.
// Every input beat is passed through unchanged. After the beat marked with
// frame_end, the trailer selected by check mode (written through mode_we and
// mode_wdata while the block is idle) follows, and out_last marks the final
// beat of the extended frame; in the none mode the passed last byte has it.
// An accepted input beat reaches the result channel through one input
// register and one output register. Data beats sustain one per cycle while
// result_stall is low and no trailer is pending; trailer beats come from the
// trailer sequencer. During a trailer the input register may still take one
// beat, and frame_stall stays high while that beat waits. Asynchronous reset
// clears the mode to none, initializes all running checks and empties both
// registers. When the receiver stalls, the output register holds its beat,
// and frame_stall rises once the input register holds a beat.
// ----------------------------------------------------------------------------
`include "frame_check_trailer_appender_core_macros.svh"

module frame_check_trailer_appender_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mode_we,
	input  logic [fcta_pkg::MODE_W-1:0] mode_wdata,
	input  logic                  frame_valid,
	output logic                  frame_stall,
	input  logic [7:0]            data_byte,
	input  logic                  frame_end,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import fcta_pkg::*;

	// Configuration and running checks.
	logic [MODE_W-1:0] mode_q;
	logic [7:0]        crc8_q;
	logic [15:0]       crc16_q;
	logic [31:0]       crc32_q;
	logic [7:0]        sum8_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Trailer sequencer: raw bytes queued in emission order, top byte next.
	logic [31:0] tr_data_q;
	logic [2:0]  tr_bytes_q;
	logic        tr_hex_q;
	logic        tr_low_q;
	logic        tr_cr_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic         out_free;
	logic         trail_act;
	logic         data_go;
	logic         trail_go;
	logic         take;
	trailer_cfg_t tcfg;
	logic [7:0]   crc8_nx;
	logic [15:0]  crc16_nx;
	logic [31:0]  crc32_nx;
	logic [31:0]  crc32_fin;
	logic [7:0]   sum8_nx;
	logic [31:0]  snap_word;
	logic [2:0]   snap_bytes;
	logic [7:0]   tr_byte;
	logic         tr_last;
	logic         tr_consume;

	// The output register can load when it is empty or its beat leaves now.
	assign out_free  = !out_valid_q || !result_stall;
	assign trail_act = (tr_bytes_q != 3'd0) || tr_cr_q;
	assign data_go   = valid_s1 && !trail_act && out_free;
	assign trail_go  = trail_act && out_free;

	// The input register refills in the same cycle that its beat moves on.
	assign frame_stall = valid_s1 && !data_go;
	assign take        = frame_valid && !frame_stall;

	assign tcfg      = decode_mode(mode_q);
	assign crc8_nx   = crc8_next(crc8_q, byte_s1);
	assign crc16_nx  = crc16_next(crc16_q, byte_s1);
	assign crc32_nx  = crc32_next(crc32_q, byte_s1);
	assign crc32_fin = crc32_nx ^ CRC32_XOROUT;
	assign sum8_nx   = sum8_q + byte_s1;

	// Trailer snapshot taken from the checks that include the last byte, laid
	// out so that the first byte to send sits in the top byte lane.
	always_comb begin
		snap_word  = 32'h0;
		snap_bytes = 3'd0;
		unique case (tcfg.src)
			SRC_CRC8: begin
				snap_word  = {crc8_nx, 24'h0};
				snap_bytes = 3'd1;
			end
			SRC_CRC16: begin
				snap_word  = tcfg.big_endian ? {crc16_nx, 16'h0}
				                             : {crc16_nx[7:0], crc16_nx[15:8], 16'h0};
				snap_bytes = 3'd2;
			end
			SRC_CRC32: begin
				snap_word  = tcfg.big_endian ? crc32_fin
				                             : {crc32_fin[7:0], crc32_fin[15:8],
				                                crc32_fin[23:16], crc32_fin[31:24]};
				snap_bytes = 3'd4;
			end
			SRC_SUM8: begin
				snap_word  = {sum8_nx, 24'h0};
				snap_bytes = 3'd1;
			end
			default: begin
				snap_word  = 32'h0;
				snap_bytes = 3'd0;
			end
		endcase
	end

	// Next trailer beat. In hex form each raw byte gives its high digit first,
	// and the byte is only consumed once its low digit has gone out. The
	// carriage return, when selected, always closes the frame.
	always_comb begin
		tr_consume = 1'b1;
		if (tr_bytes_q != 3'd0) begin
			if (tr_hex_q) begin
				tr_byte    = tr_low_q ? hex_ascii(tr_data_q[27:24])
				                      : hex_ascii(tr_data_q[31:28]);
				tr_consume = tr_low_q;
			end else begin
				tr_byte = tr_data_q[31:24];
			end
			tr_last = tr_consume && (tr_bytes_q == 3'd1) && !tr_cr_q;
		end else begin
			tr_byte = ASCII_CR;
			tr_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Running checks restart after each frame's last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc8_q  <= CRC8_INIT;
			crc16_q <= CRC16_INIT;
			crc32_q <= CRC32_INIT;
			sum8_q  <= SUM8_INIT;
		end else if (data_go) begin
			if (end_s1) begin
				crc8_q  <= CRC8_INIT;
				crc16_q <= CRC16_INIT;
				crc32_q <= CRC32_INIT;
				sum8_q  <= SUM8_INIT;
			end else begin
				crc8_q  <= crc8_nx;
				crc16_q <= crc16_nx;
				crc32_q <= crc32_nx;
				sum8_q  <= sum8_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (data_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_bytes_q <= 3'd0;
			tr_low_q   <= 1'b0;
			tr_cr_q    <= 1'b0;
		end else if (data_go && end_s1) begin
			tr_bytes_q <= snap_bytes;
			tr_low_q   <= 1'b0;
			tr_cr_q    <= tcfg.cr;
		end else if (trail_go) begin
			if (tr_bytes_q != 3'd0) begin
				if (tr_consume) begin
					tr_bytes_q <= tr_bytes_q - 3'd1;
					tr_low_q   <= 1'b0;
				end else begin
					tr_low_q <= 1'b1;
				end
			end else begin
				tr_cr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_go && end_s1) begin
			tr_data_q <= snap_word;
			tr_hex_q  <= tcfg.hex;
		end else if (trail_go && (tr_bytes_q != 3'd0) && tr_consume) begin
			tr_data_q <= {tr_data_q[23:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (data_go || trail_go) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_go) begin
			out_byte_q <= byte_s1;
			out_last_q <= end_s1 && (tcfg.src == SRC_NONE);
		end else if (trail_go) begin
			out_byte_q <= tr_byte;
			out_last_q <= tr_last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;

	// No data beat may slip in between trailer beats.
	`FCTA_ASSERT_IMPLY(a_no_data_in_trailer, clk, arst_n, trail_act, !data_go)
	// A low hex digit is only pending in hex form.
	`FCTA_ASSERT_IMPLY(a_low_digit_hex_only, clk, arst_n, tr_low_q, tr_hex_q)
	// At most one 32-bit check is ever queued.
	`FCTA_ASSERT_IMPLY(a_trailer_depth, clk, arst_n, 1'b1, tr_bytes_q <= 3'd4)
	// The CRC-8, CRC-32 and sum checks restart once a frame's last byte is taken.
	`FCTA_ASSERT_NEXT(a_checks_restart, clk, arst_n, data_go && end_s1,
		(crc8_q == CRC8_INIT) && (crc32_q == CRC32_INIT) && (sum8_q == SUM8_INIT))

endmodule
